// ===== sv/ddf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types and constants of the detection decode and filter unit.
// ----------------------------------------------------------------------------
package ddf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_CONF   = 2'd0,
    REG_NET_WIDTH  = 2'd1,
    REG_NET_HEIGHT = 2'd2
  } reg_index_t;

  localparam logic [15:0] MIN_CONF_RST = 16'd32768;
  localparam logic [12:0] NET_SIZE_RST = 13'd640;

  // round(65536 * sigmoid(k/2)), k = 0..16
  localparam logic [15:0] SIG_TABLE [0:16] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  // Load enables of the pipeline stages behind the first one
  typedef struct packed {
    logic en2;
    logic en3;
  } pipe_en_t;

endpackage

// ===== sv/ddf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddf_det_if / ddf_res_if
// Valid/ready channels for incoming detections and outgoing results.
// ----------------------------------------------------------------------------
interface ddf_det_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit_a;
  logic signed [15:0] logit_b;
  logic signed [15:0] logit_c;
  logic signed [15:0] logit_d;
  logic signed [15:0] logit_e;
  logic        [15:0] center_x;
  logic        [15:0] center_y;
  logic        [15:0] box_w;
  logic        [15:0] box_h;

  modport source (output valid, logit_a, logit_b, logit_c, logit_d, logit_e,
                  center_x, center_y, box_w, box_h, input ready);
  modport sink (input valid, logit_a, logit_b, logit_c, logit_d, logit_e,
                center_x, center_y, box_w, box_h, output ready);
endinterface

interface ddf_res_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  label;
  logic        [15:0] confidence;
  logic signed [16:0] left_px;
  logic signed [16:0] top_px;
  logic        [15:0] width_px;
  logic        [15:0] height_px;

  modport source (output valid, label, confidence, left_px, top_px,
                  width_px, height_px, input ready);
  modport sink (input valid, label, confidence, left_px, top_px,
                width_px, height_px, output ready);
endinterface

// ===== sv/ddf_sigmoid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddf_sigmoid
// Two-stage table sigmoid with linear interpolation, Q8.8 in, Q0.16 out.
// ----------------------------------------------------------------------------
module ddf_sigmoid
  import ddf_pkg::*;
(
  input  logic               clk,
  input  pipe_en_t           en,
  input  logic signed [15:0] logit,
  output logic        [15:0] conf
);

  logic        [16:0] mag;
  logic               sat;
  logic        [3:0]  seg;
  logic        [6:0]  frac;
  logic        [15:0] lo_val;
  logic        [15:0] hi_val;
  logic        [12:0] diff;
  logic        [15:0] base;
  logic        [19:0] prod;
  logic               neg;
  logic        [15:0] s_val;

  // Magnitude and table segment
  always_comb begin
    mag    = logit[15] ? 17'(-$signed({logit[15], logit})) : 17'({1'b0, logit});
    sat    = |mag[16:11];
    seg    = mag[10:7];
    frac   = mag[6:0];
    lo_val = SIG_TABLE[{1'b0, seg}];
    hi_val = SIG_TABLE[5'({1'b0, seg}) + 5'd1];
    diff   = 13'(hi_val - lo_val);
  end

  // Stage 2: segment base and slope product
  always_ff @(posedge clk) begin
    if (en.en2) begin
      base <= sat ? SIG_TABLE[16] : lo_val;
      prod <= sat ? 20'd0 : 20'(diff * frac);
      neg  <= logit[15];
    end
  end

  // Stage 3: round, add, mirror for negative logits
  assign s_val = 16'(base + 16'((prod + 20'd64) >> 7));

  always_ff @(posedge clk) begin
    if (en.en3) begin
      conf <= neg ? 16'(17'd65536 - {1'b0, s_val}) : s_val;
    end
  end

endmodule

// ===== sv/detection_decode_filter_unit.sv =====
`timescale 1ns / 1ps
// Path: stage 1, 2 and 3 registers, then the output register, to res.
// Throughput: one detection per cycle; each stage stalls only when the
//   stage after it is full and cannot move, so the output register decides.
// Reset (rst, synchronous): pipeline valids cleared, min_conf = 32768,
//   net_width = net_height = 640.
// ----------------------------------------------------------------------------
// detection_decode_filter_unit
// Argmax over five logits, sigmoid confidence, threshold filter and box
// scaling to 1/16-pixel units with saturation.
// ----------------------------------------------------------------------------
module detection_decode_filter_unit
  import ddf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ddf_det_if.sink     det,
  ddf_res_if.source   res,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  logic [15:0] min_conf;
  logic [12:0] net_width;
  logic [12:0] net_height;

  logic        v1, v2, v3, vo;
  logic        take_o, en1;
  pipe_en_t    en;

  // Stage 1 signals
  logic signed [15:0] win_ab, win_cd, win_abcd, win;
  logic        [2:0]  cls_ab, cls_cd, cls_abcd, cls_win;
  logic signed [15:0] best1;
  logic        [2:0]  cls1, cls2, cls3;
  logic signed [17:0] dx1, dy1;
  logic        [15:0] bw1, bh1;

  // Stage 2 signals
  logic signed [31:0] mx2, my2;
  logic        [28:0] mw2, mh2;

  // Stage 3 signals
  logic signed [31:0] sum_x, sum_y, q_x, q_y;
  logic        [29:0] sum_w, sum_h;
  logic        [17:0] q_w, q_h;
  logic signed [16:0] left3, top3;
  logic        [15:0] width3, height3;
  logic        [15:0] conf3;
  logic               pass3;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_conf   <= MIN_CONF_RST;
      net_width  <= NET_SIZE_RST;
      net_height <= NET_SIZE_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_MIN_CONF:   min_conf   <= wr_data;
        REG_NET_WIDTH:  net_width  <= wr_data[12:0];
        REG_NET_HEIGHT: net_height <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  // Stall chain: a stage loads when empty or when its content moves on
  assign take_o = !vo || res.ready;
  assign en.en3 = !v3 || take_o;
  assign en.en2 = !v2 || en.en3;
  assign en1    = !v1 || en.en2;
  assign det.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1)    v1 <= det.valid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (take_o) vo <= v3 && pass3;
    end
  end

  // Argmax tree; the right side wins only when strictly greater
  always_comb begin
    win_ab   = (det.logit_b > det.logit_a) ? det.logit_b : det.logit_a;
    cls_ab   = (det.logit_b > det.logit_a) ? 3'd1 : 3'd0;
    win_cd   = (det.logit_d > det.logit_c) ? det.logit_d : det.logit_c;
    cls_cd   = (det.logit_d > det.logit_c) ? 3'd3 : 3'd2;
    win_abcd = (win_cd > win_ab) ? win_cd : win_ab;
    cls_abcd = (win_cd > win_ab) ? cls_cd : cls_ab;
    win      = (det.logit_e > win_abcd) ? det.logit_e : win_abcd;
    cls_win  = (det.logit_e > win_abcd) ? 3'd4 : cls_abcd;
  end

  // Stage 1: winner and box edge offsets (2*center - size)
  always_ff @(posedge clk) begin
    if (en1) begin
      best1 <= win;
      cls1  <= cls_win;
      dx1   <= $signed({1'b0, det.center_x, 1'b0}) - $signed({2'b00, det.box_w});
      dy1   <= $signed({1'b0, det.center_y, 1'b0}) - $signed({2'b00, det.box_h});
      bw1   <= det.box_w;
      bh1   <= det.box_h;
    end
  end

  // Stage 2: scale by network size
  always_ff @(posedge clk) begin
    if (en.en2) begin
      cls2 <= cls1;
      mx2  <= 32'(dx1 * $signed({1'b0, net_width}));
      my2  <= 32'(dy1 * $signed({1'b0, net_height}));
      mw2  <= 29'(bw1 * net_width);
      mh2  <= 29'(bh1 * net_height);
    end
  end

  ddf_sigmoid u_sigmoid (
    .clk   (clk),
    .en    (en),
    .logit (best1),
    .conf  (conf3)
  );

  // Stage 3: round, shift and saturate
  always_comb begin
    sum_x = mx2 + 32'sd4096;
    sum_y = my2 + 32'sd4096;
    q_x   = sum_x >>> 13;
    q_y   = sum_y >>> 13;
    sum_w = {1'b0, mw2} + 30'd2048;
    sum_h = {1'b0, mh2} + 30'd2048;
    q_w   = sum_w[29:12];
    q_h   = sum_h[29:12];
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      cls3 <= cls2;
      if (q_x < -32'sd32768)     left3 <= -17'sd32768;
      else if (q_x > 32'sd65535) left3 <= 17'sd65535;
      else                       left3 <= q_x[16:0];
      if (q_y < -32'sd32768)     top3 <= -17'sd32768;
      else if (q_y > 32'sd65535) top3 <= 17'sd65535;
      else                       top3 <= q_y[16:0];
      width3  <= (|q_w[17:16]) ? 16'hFFFF : q_w[15:0];
      height3 <= (|q_h[17:16]) ? 16'hFFFF : q_h[15:0];
    end
  end

  // Threshold filter
  assign pass3 = (conf3 >= min_conf);

  // Output register
  always_ff @(posedge clk) begin
    if (take_o && v3) begin
      res.label      <= cls3;
      res.confidence <= conf3;
      res.left_px    <= left3;
      res.top_px     <= top3;
      res.width_px   <= width3;
      res.height_px  <= height3;
    end
  end

  assign res.valid = vo;

  // Checks
  a_pass_thr: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.confidence >= min_conf)
    else $error("result below confidence threshold");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.label <= 3'd4)
    else $error("class index out of range");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.confidence >= 16'd22 && res.confidence <= 16'd65514))
    else $error("confidence outside sigmoid range");

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en.en3) |=> (v3 && $stable(conf3) && $stable(cls3)))
    else $error("stalled stage 3 lost its contents");

endmodule

// ===== tb/tb_detection_decode_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_decode_filter_unit
// Streams detections into the decode and filter unit and compares every
// result with a local model of argmax, sigmoid table lookup, threshold and
// box scaling, or a typed one. A short table of hand-picked detections
// comes first, then random traffic over several register settings, with
// random gaps on the detection side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_detection_decode_filter_unit
  import ddf_pkg::*;
();

  localparam int      SETTLE_CYCLES = 10;         // pipeline is 4 deep
  localparam int      END_WAIT_MAX  = 5000;
  localparam longint  WATCHDOG_NS   = 20_000_000;
  localparam logic [1:0] REG_UNUSED = 2'd3;       // no register behind it

  // round(65536 * sigmoid(k/2)), k = 0..16
  localparam int SIGMOID_LUT [0:16] = '{
    32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
    64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
  };

  typedef struct packed {
    logic [4:0][15:0] logit;
    logic [15:0]      center_x;
    logic [15:0]      center_y;
    logic [15:0]      box_w;
    logic [15:0]      box_h;
  } det_t;

  typedef struct packed {
    logic        [2:0]  label;
    logic        [15:0] confidence;
    logic signed [16:0] left_px;
    logic signed [16:0] top_px;
    logic        [15:0] width_px;
    logic        [15:0] height_px;
  } result_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_KEPT,
    CHECK_DROPPED
  } row_check_t;

  typedef struct {
    det_t       det;
    row_check_t check;
    result_t    res;
  } row_t;

  typedef struct {
    logic [15:0] threshold;
    logic [15:0] width_data;
    logic [15:0] height_data;
    int          count;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;

  ddf_det_if det_ch ();
  ddf_res_if res_ch ();

  detection_decode_filter_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .det      (det_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Local copy of the registers
  logic [15:0] model_threshold;
  logic [12:0] model_net_w;
  logic [12:0] model_net_h;

  result_t     pending_results [$];
  row_t        directed_rows [$];
  bit          src_gaps;
  bit          sink_stalls;
  int unsigned n_sent;
  int unsigned n_kept;
  int unsigned n_dropped;
  int unsigned n_errors;
  int unsigned n_settings;

  // Queue helpers
  function automatic void expect_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(input row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit
  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------- predictor ----------------

  function automatic logic [15:0] sigmoid_of(logic signed [15:0] x);
    int mag, idx, frac, s;
    mag = (x < 0) ? -int'(x) : int'(x);
    if (mag >= 2048) begin
      s = SIGMOID_LUT[16];
    end else begin
      idx  = mag >> 7;
      frac = mag & 127;
      s = SIGMOID_LUT[idx] +
          (((SIGMOID_LUT[idx + 1] - SIGMOID_LUT[idx]) * frac + 64) >> 7);
    end
    if (x < 0) s = 65536 - s;
    return s[15:0];
  endfunction

  // floor(((2*center - extent)*n + 4096) / 8192), clamped to -32768..65535
  function automatic logic signed [16:0] scale_edge(logic [15:0] center,
                                                    logic [15:0] extent,
                                                    logic [12:0] n);
    longint v;
    v = (2 * longint'(center) - longint'(extent)) * longint'(n) + 4096;
    v = v >>> 13;
    if (v < -32768) v = -32768;
    if (v > 65535) v = 65535;
    return v[16:0];
  endfunction

  function automatic logic [15:0] scale_size(logic [15:0] extent, logic [12:0] n);
    longint v;
    v = (longint'(extent) * longint'(n) + 2048) >> 12;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Returns 1 when the detection survives the threshold
  function automatic bit decode_detection(input det_t d, output result_t r);
    logic signed [15:0] best;
    logic [15:0]        conf;
    int                 cls;
    best = $signed(d.logit[0]);
    cls  = 0;
    for (int c = 1; c < 5; c++) begin
      if ($signed(d.logit[c]) > best) begin
        best = $signed(d.logit[c]);
        cls  = c;
      end
    end
    conf = sigmoid_of(best);
    r = '0;
    if (conf < model_threshold) return 1'b0;
    r.label      = cls[2:0];
    r.confidence = conf;
    r.left_px    = scale_edge(d.center_x, d.box_w, model_net_w);
    r.top_px     = scale_edge(d.center_y, d.box_h, model_net_h);
    r.width_px   = scale_size(d.box_w, model_net_w);
    r.height_px  = scale_size(d.box_h, model_net_h);
    return 1'b1;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic det_t det_of(int la, int lb, int lc, int ld, int le,
                                  int cx, int cy, int bw, int bh);
    det_t d;
    d.logit[0] = la[15:0];
    d.logit[1] = lb[15:0];
    d.logit[2] = lc[15:0];
    d.logit[3] = ld[15:0];
    d.logit[4] = le[15:0];
    d.center_x = cx[15:0];
    d.center_y = cy[15:0];
    d.box_w    = bw[15:0];
    d.box_h    = bh[15:0];
    return d;
  endfunction

  function automatic det_t random_detection();
    det_t d;
    int   v;
    for (int c = 0; c < 5; c++) begin
      case ($urandom_range(0, 7))
        0, 1:    v = $urandom;
        2, 3, 4: v = int'($urandom_range(0, 4600)) - 2300; // table region
        5:       v = $urandom_range(0, 1) ? 32'sd32767 : -32'sd32768;
        default: v = (c > 0) ? int'($signed(d.logit[c - 1])) : 0; // tie
      endcase
      d.logit[c] = v[15:0];
    end
    case ($urandom_range(0, 5))
      0: begin
        d.center_x = 16'($urandom);
        d.center_y = 16'($urandom);
        d.box_w    = 16'($urandom);
        d.box_h    = 16'($urandom);
      end
      1: begin
        d.center_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        d.center_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        d.box_w    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        d.box_h    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        d.center_x = 16'($urandom);
        d.center_y = 16'($urandom);
        d.box_w    = 16'($urandom_range(0, 20000));
        d.box_h    = 16'($urandom_range(0, 20000));
      end
    endcase
    return d;
  endfunction

  // Register write; called and returns just after a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_CONF:   model_threshold = data;
      REG_NET_WIDTH:  model_net_w     = data[12:0];
      REG_NET_HEIGHT: model_net_h     = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // One detection transaction; called and returns just after a falling edge
  task automatic send_detection(input det_t d, input row_check_t how,
                                input result_t typed);
    int      gap;
    result_t r;
    gap = (src_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      det_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    det_ch.valid    <= 1'b1;
    det_ch.logit_a  <= d.logit[0];
    det_ch.logit_b  <= d.logit[1];
    det_ch.logit_c  <= d.logit[2];
    det_ch.logit_d  <= d.logit[3];
    det_ch.logit_e  <= d.logit[4];
    det_ch.center_x <= d.center_x;
    det_ch.center_y <= d.center_y;
    det_ch.box_w    <= d.box_w;
    det_ch.box_h    <= d.box_h;
    do @(posedge clk); while (det_ch.ready !== 1'b1);
    n_sent++;
    case (how)
      CHECK_KEPT:    expect_result(typed);
      CHECK_DROPPED: n_dropped++;
      default: begin
        if (decode_detection(d, r)) expect_result(r);
        else n_dropped++;
      end
    endcase
    @(negedge clk);
  endtask

  // Stop sending and let every expected result and dropped item drain
  task automatic wait_idle();
    det_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    wait_idle();
    write_reg(REG_MIN_CONF, s.threshold);
    write_reg(REG_NET_WIDTH, s.width_data);
    write_reg(REG_NET_HEIGHT, s.height_data);
    write_reg(REG_UNUSED, 16'($urandom));
    n_settings++;
    src_gaps    = $urandom_range(0, 3) != 0;
    sink_stalls = $urandom_range(0, 3) != 0;
    repeat (s.count) send_detection(random_detection(), CHECK_PREDICTED, '0);
  endtask

  // ---------------- result side ----------------

  // Random back-pressure on the result channel
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, got class %0d conf %0d",
                 $time, res_ch.label, res_ch.confidence);
      end else begin
        want = pending_results.pop_front();
        n_kept++;
        compare_field("label", 32'(want.label), 32'(res_ch.label));
        compare_field("confidence", 32'(want.confidence), 32'(res_ch.confidence));
        compare_field("left_px", 32'(want.left_px), 32'(res_ch.left_px));
        compare_field("top_px", 32'(want.top_px), 32'(res_ch.top_px));
        compare_field("width_px", 32'(want.width_px), 32'(res_ch.width_px));
        compare_field("height_px", 32'(want.height_px), 32'(res_ch.height_px));
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    setting_t fixed_settings [5];
    setting_t s;
    int       waited;

    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = 2'd0;
    wr_data         = 16'd0;
    det_ch.valid    = 1'b0;
    det_ch.logit_a  = 16'sd0;
    det_ch.logit_b  = 16'sd0;
    det_ch.logit_c  = 16'sd0;
    det_ch.logit_d  = 16'sd0;
    det_ch.logit_e  = 16'sd0;
    det_ch.center_x = 16'd0;
    det_ch.center_y = 16'd0;
    det_ch.box_w    = 16'd0;
    det_ch.box_h    = 16'd0;
    src_gaps        = 1'b0;
    sink_stalls     = 1'b1;
    model_threshold = 16'd32768;
    model_net_w     = 13'd640;
    model_net_h     = 13'd640;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Hand-picked detections under the reset settings
    // all zero: five-way tie, confidence equal to threshold
    add_row('{det_of(0, 0, 0, 0, 0, 0, 0, 0, 0), CHECK_KEPT,
              '{3'd0, 16'd32768, 17'sd0, 17'sd0, 16'd0, 16'd0}});
    // most negative logits everywhere: lowest confidence, dropped
    add_row('{det_of(-32768, -32768, -32768, -32768, -32768,
                     65535, 65535, 65535, 65535), CHECK_DROPPED, '0});
    // saturated sigmoid on the last class
    add_row('{det_of(-32768, -32768, -32768, -32768, 32767,
                     0, 0, 0, 0), CHECK_KEPT,
              '{3'd4, 16'd65514, 17'sd0, 17'sd0, 16'd0, 16'd0}});
    // tie between classes 1 and 3 on an exact table point
    add_row('{det_of(0, 256, 0, 256, 0, 0, 0, 0, 0), CHECK_KEPT,
              '{3'd1, 16'd47911, 17'sd0, 17'sd0, 16'd0, 16'd0}});
    add_row('{det_of(-1, -1, -1, -1, -1, 100, 200, 300, 400),
              CHECK_PREDICTED, '0});
    add_row('{det_of(32767, 0, 0, 0, 0, 0, 0, 65535, 65535),
              CHECK_PREDICTED, '0});
    add_row('{det_of(0, 0, 32767, 0, 0, 65535, 65535, 0, 0),
              CHECK_PREDICTED, '0});
    add_row('{det_of(0, 0, 2047, 0, 0, 32768, 32768, 1000, 2000),
              CHECK_PREDICTED, '0});
    add_row('{det_of(0, 0, 0, 2048, 0, 65535, 0, 65535, 0),
              CHECK_PREDICTED, '0});
    add_row('{det_of(-32768, -32767, -32768, -32768, -32768,
                     1, 1, 1, 1), CHECK_PREDICTED, '0});
    add_row('{det_of(-5, -5, -5, -5, 128, 32768, 32768, 16384, 16384),
              CHECK_PREDICTED, '0});
    add_row('{det_of(-256, -300, -400, -500, -600, 0, 65535, 65535, 1),
              CHECK_PREDICTED, '0});
    add_row('{det_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                     16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555),
              CHECK_PREDICTED, '0});
    add_row('{det_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                     16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA),
              CHECK_PREDICTED, '0});
    add_row('{det_of(127, 129, 1, -129, -127, 4096, 61440, 8192, 8192),
              CHECK_PREDICTED, '0});
    n_settings = 1;
    foreach (directed_rows[i])
      send_detection(directed_rows[i].det, directed_rows[i].check, directed_rows[i].res);

    // Corner settings: zero network size, nothing passes, largest and
    // smallest sizes, the confidence extremes as threshold, masked size bits
    fixed_settings[0] = '{16'd0,     16'd0,    16'd0,    40};
    fixed_settings[1] = '{16'd65535, 16'hFFFF, 16'h1FFF, 20};
    fixed_settings[2] = '{16'd0,     16'hFFFF, 16'd1,    40};
    fixed_settings[3] = '{16'd22,    16'd4096, 16'd4096, 40};
    fixed_settings[4] = '{16'd65514, 16'd1,    16'h2280, 40};
    foreach (fixed_settings[i]) apply_setting(fixed_settings[i]);

    // Random settings, mostly sizes in the usual range and a loose threshold
    repeat (11) begin
      s.threshold   = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                                                   16'($urandom_range(0, 40000));
      s.width_data  = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                                                   16'($urandom_range(1, 4096));
      s.height_data = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                                                   16'($urandom_range(1, 4096));
      s.count       = 100;
      apply_setting(s);
    end

    // Drain
    det_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_MAX) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      n_errors += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("Sent %0d detections over %0d register settings: %0d kept, %0d filtered.",
             n_sent, n_settings, n_kept, n_dropped);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
